// File: hdl/tssm_pkg.sv
package tssm_pkg;

   // Sizes fixed by the beat formats
   localparam int WORD_W        = 32;
   localparam int OCC_W         = 5;
   localparam int DEPTH_DEFAULT = 16;

   // Request codes
   localparam logic       OP_PUSH = 1'b0;
   localparam logic       OP_POP  = 1'b1;

   localparam logic [1:0] STK_NONE = 2'd0;
   localparam logic [1:0] STK_LOW  = 2'd1;
   localparam logic [1:0] STK_HIGH = 2'd2;
   localparam logic [1:0] STK_MID  = 2'd3;

   // Result codes
   localparam logic       STATUS_OK   = 1'b0;
   localparam logic       STATUS_FAIL = 1'b1;

   localparam logic signed [WORD_W-1:0] READ_NONE = '1;

   typedef struct packed {
      logic                     opcode;
      logic [1:0]               stack_id;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic                     status;
      logic signed [WORD_W-1:0] read_value;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_MOVE_END,
      ST_POP_WAIT,
      ST_DONE
   } state_type;

endpackage

// File: hdl/tssm_ram.sv
module tssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word, register one read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hdl/three_stacks_shared_memory_core.sv
// Push, failed request: taken only in idle, decided in execute, result beat registered from done.
// Successful pop: adds a wait state for the registered read of the word store.
// Push that moves the middle stack: adds move end and a return to execute, plus a read and a
// write state per middle-stack word, copied pairwise through the single-port-pair word store.
// Synchronous reset: pointers to their home positions, move history cleared, no result pending;
// the word store is not cleared.
module three_stacks_shared_memory_core #(
   parameter int DEPTH = tssm_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tssm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tssm_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH) + 2;
   localparam int CW = (PW + 1 > tssm_pkg::OCC_W) ? PW + 1 : tssm_pkg::OCC_W;

   tssm_pkg::state_type state_ff, state_in;

   tssm_pkg::req_type   req_ff, req_in;
   logic signed [PW-1:0] low_top_ff, low_top_in;
   logic signed [PW-1:0] high_next_ff, high_next_in;
   logic signed [PW-1:0] mid_base_ff, mid_base_in;
   logic signed [PW-1:0] mid_top_ff, mid_top_in;
   logic signed [PW-1:0] prev_shift_ff, prev_shift_in;
   logic signed [PW-1:0] shift_amt_ff, shift_amt_in;
   logic [AW-1:0]        copy_idx_ff, copy_idx_in;
   logic [PW-1:0]        copy_cnt_ff, copy_cnt_in;
   logic                 status_ff, status_in;
   logic signed [tssm_pkg::WORD_W-1:0] read_ff, read_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tssm_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // Word store ports
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [tssm_pkg::WORD_W-1:0] ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [tssm_pkg::WORD_W-1:0] ram_rdata;

   // Decision terms
   logic                 req_accept;
   logic                 rsp_free;
   logic                 is_push;
   logic                 id_valid;
   logic                 low_has_room;
   logic                 mid_has_room;
   logic                 need_shift;
   logic                 shift_up;
   logic                 pop_ok;
   logic [PW-1:0]        up_room;
   logic [PW-1:0]        down_room;
   logic [PW-1:0]        prev_neg;
   logic [PW:0]          want_up;
   logic [PW:0]          want_down;
   logic [PW:0]          mag_up;
   logic [PW:0]          mag_down;
   logic [PW-1:0]        shift_mag;
   logic signed [PW-1:0] shift_amt;
   logic [PW-1:0]        mid_count;
   logic [CW-1:0]        occ_wide;

   tssm_ram #(
      .WIDTH (tssm_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall  = (state_ff != tssm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Room checks and size of the next middle-stack move
   assign is_push      = (req_ff.opcode == tssm_pkg::OP_PUSH);
   assign id_valid     = (req_ff.stack_id != tssm_pkg::STK_NONE);
   assign shift_up     = (req_ff.stack_id == tssm_pkg::STK_LOW);
   assign low_has_room = (low_top_ff != mid_base_ff);
   assign mid_has_room = (mid_top_ff <= high_next_ff);
   assign need_shift   = shift_up ? !low_has_room : !mid_has_room;
   assign up_room      = PW'(high_next_ff - mid_top_ff + PW'(1));
   assign down_room    = PW'(mid_base_ff - low_top_ff);
   assign prev_neg     = PW'(-prev_shift_ff);

   assign want_up   = (!prev_shift_ff[PW-1] && prev_shift_ff != '0) ?
                      {prev_shift_ff, 1'b0} : (PW+1)'(1);
   assign want_down = prev_shift_ff[PW-1] ? {prev_neg, 1'b0} : (PW+1)'(1);
   assign mag_up    = (want_up < {1'b0, up_room}) ? want_up : {1'b0, up_room};
   assign mag_down  = (want_down < {1'b0, down_room}) ? want_down : {1'b0, down_room};
   assign shift_mag = shift_up ? mag_up[PW-1:0] : mag_down[PW-1:0];
   assign shift_amt = shift_up ? signed'(shift_mag) : -signed'(shift_mag);
   assign mid_count = PW'(mid_top_ff - mid_base_ff);

   always_comb begin
      case (req_ff.stack_id)
         tssm_pkg::STK_LOW:  pop_ok = (low_top_ff != '0);
         tssm_pkg::STK_HIGH: pop_ok = (high_next_ff != PW'(DEPTH - 1));
         tssm_pkg::STK_MID:  pop_ok = (mid_top_ff != mid_base_ff);
         default:            pop_ok = 1'b0;
      endcase
   end

   // Total held words, reported modulo the field width
   assign occ_wide = CW'(low_top_ff) + CW'(DEPTH - 1) - CW'(high_next_ff)
                   + CW'(mid_top_ff) - CW'(mid_base_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tssm_pkg::ST_IDLE: begin
            if (req_accept) state_in = tssm_pkg::ST_EXEC;
         end
         tssm_pkg::ST_EXEC: begin
            if (is_push) begin
               if (id_valid && need_shift && shift_mag != '0) begin
                  state_in = (mid_count == '0) ? tssm_pkg::ST_MOVE_END : tssm_pkg::ST_COPY_RD;
               end else begin
                  state_in = tssm_pkg::ST_DONE;
               end
            end else begin
               state_in = pop_ok ? tssm_pkg::ST_POP_WAIT : tssm_pkg::ST_DONE;
            end
         end
         tssm_pkg::ST_COPY_RD: state_in = tssm_pkg::ST_COPY_WR;
         tssm_pkg::ST_COPY_WR: begin
            state_in = (copy_cnt_ff == PW'(1)) ? tssm_pkg::ST_MOVE_END : tssm_pkg::ST_COPY_RD;
         end
         tssm_pkg::ST_MOVE_END: state_in = tssm_pkg::ST_EXEC;
         tssm_pkg::ST_POP_WAIT: state_in = tssm_pkg::ST_DONE;
         tssm_pkg::ST_DONE: begin
            if (rsp_free) state_in = tssm_pkg::ST_IDLE;
         end
         default: state_in = tssm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and store control
   always_comb begin
      req_in        = req_ff;
      low_top_in    = low_top_ff;
      high_next_in  = high_next_ff;
      mid_base_in   = mid_base_ff;
      mid_top_in    = mid_top_ff;
      prev_shift_in = prev_shift_ff;
      shift_amt_in  = shift_amt_ff;
      copy_idx_in   = copy_idx_ff;
      copy_cnt_in   = copy_cnt_ff;
      status_in     = status_ff;
      read_in       = read_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      case (state_ff)
         tssm_pkg::ST_IDLE: begin
            // Capture the request beat
            if (req_accept) req_in = req_data;
         end
         tssm_pkg::ST_EXEC: begin
            status_in = tssm_pkg::STATUS_FAIL;
            read_in   = tssm_pkg::READ_NONE;
            if (is_push) begin
               if (!id_valid) begin
                  status_in = tssm_pkg::STATUS_FAIL;
               end else if (need_shift) begin
                  // Start a move of the middle stack; a zero move clears the history
                  prev_shift_in = shift_amt;
                  shift_amt_in  = shift_amt;
                  copy_cnt_in   = mid_count;
                  copy_idx_in   = shift_up ? AW'(mid_top_ff - PW'(1)) : mid_base_ff[AW-1:0];
               end else begin
                  status_in = tssm_pkg::STATUS_OK;
                  ram_we    = 1'b1;
                  ram_wdata = req_ff.push_value;
                  case (req_ff.stack_id)
                     tssm_pkg::STK_LOW: begin
                        ram_waddr  = low_top_ff[AW-1:0];
                        low_top_in = low_top_ff + PW'(1);
                     end
                     tssm_pkg::STK_HIGH: begin
                        ram_waddr    = high_next_ff[AW-1:0];
                        high_next_in = high_next_ff - PW'(1);
                     end
                     default: begin
                        ram_waddr  = mid_top_ff[AW-1:0];
                        mid_top_in = mid_top_ff + PW'(1);
                     end
                  endcase
               end
            end else if (pop_ok) begin
               // Drop the top entry and fetch it
               status_in = tssm_pkg::STATUS_OK;
               case (req_ff.stack_id)
                  tssm_pkg::STK_LOW: begin
                     low_top_in = low_top_ff - PW'(1);
                     ram_raddr  = AW'(low_top_ff - PW'(1));
                  end
                  tssm_pkg::STK_HIGH: begin
                     high_next_in = high_next_ff + PW'(1);
                     ram_raddr    = AW'(high_next_ff + PW'(1));
                  end
                  default: begin
                     mid_top_in = mid_top_ff - PW'(1);
                     ram_raddr  = AW'(mid_top_ff - PW'(1));
                  end
               endcase
            end
         end
         tssm_pkg::ST_COPY_RD: begin
            ram_raddr = copy_idx_ff;
         end
         tssm_pkg::ST_COPY_WR: begin
            // Move one word and advance away from the free side
            ram_we      = 1'b1;
            ram_waddr   = copy_idx_ff + shift_amt_ff[AW-1:0];
            ram_wdata   = ram_rdata;
            copy_idx_in = shift_amt_ff[PW-1] ? copy_idx_ff + AW'(1) : copy_idx_ff - AW'(1);
            copy_cnt_in = copy_cnt_ff - PW'(1);
         end
         tssm_pkg::ST_MOVE_END: begin
            mid_base_in = mid_base_ff + shift_amt_ff;
            mid_top_in  = mid_top_ff + shift_amt_ff;
         end
         tssm_pkg::ST_POP_WAIT: begin
            read_in = ram_rdata;
         end
         tssm_pkg::ST_DONE: begin
            // Load the result beat once the output register is free
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status_ff;
               rsp_data_in.read_value = read_ff;
               rsp_data_in.occupancy  = occ_wide[tssm_pkg::OCC_W-1:0];
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tssm_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         low_top_ff    <= '0;
         high_next_ff  <= PW'(DEPTH - 1);
         mid_base_ff   <= PW'(DEPTH / 2);
         mid_top_ff    <= PW'(DEPTH / 2);
         prev_shift_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         low_top_ff    <= low_top_in;
         high_next_ff  <= high_next_in;
         mid_base_ff   <= mid_base_in;
         mid_top_ff    <= mid_top_in;
         prev_shift_ff <= prev_shift_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      shift_amt_ff <= shift_amt_in;
      copy_idx_ff  <= copy_idx_in;
      copy_cnt_ff  <= copy_cnt_in;
      status_ff    <= status_in;
      read_ff      <= read_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
